// ===== rtl/core/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants for the broadcast drop-oldest queues.
// ----------------------------------------------------------------------------
package bdq_pkg;

	// default sizing
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int NUM_QUEUES_DEF  = 8;
	localparam int FRAME_BITS_DEF  = 64;

	// fixed field widths
	localparam int MODE_W   = 1;
	localparam int QIDX_W   = 3;
	localparam int FRAME_W  = 64;
	localparam int STATUS_W = 1;
	localparam int ACTIVE_W = 4;

	// request kinds
	localparam logic [MODE_W-1:0] MODE_PUSH = 1'b0;
	localparam logic [MODE_W-1:0] MODE_POP  = 1'b1;

	// result status
	localparam logic [STATUS_W-1:0] STATUS_OK    = 1'b0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 1'b1;

endpackage

// ===== rtl/core/bdq_if.sv =====
// ----------------------------------------------------------------------------
// bdq_in_if / bdq_out_if
// Valid/ready channels for requests and results of the queue block.
// ----------------------------------------------------------------------------
interface bdq_in_if
	import bdq_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [QIDX_W-1:0]  queue_index;
	logic [FRAME_W-1:0] frame_in;

	modport source (output valid, mode, queue_index, frame_in, input ready);
	modport sink   (input valid, mode, queue_index, frame_in, output ready);
endinterface

interface bdq_out_if
	import bdq_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FRAME_W-1:0]  frame_out;

	modport source (output valid, status, frame_out, input ready);
	modport sink   (input valid, status, frame_out, output ready);
endinterface

// ===== rtl/core/broadcast_drop_oldest_queues.sv =====
// ----------------------------------------------------------------------------
// broadcast_drop_oldest_queues
// Per-subscriber circular queues fed by broadcast; full queues drop oldest.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_req    in   valid / ready      mode, queue_index, frame_in
//  out_rsp   out  valid / ready      status, frame_out
//  cfg       in   cfg_wr_en          cfg_wr_data (active queue count)
//
//  A push writes the active queues in turn, one queue per cycle, through the
//  single write port of the shared frame memory. A pop goes through a
//  registered memory read (rd_q); a pop that finds nothing skips the read.
//  arst_n clears pointers, fill counts, count register and sequencer.
//  A request is taken only when the sequencer is idle; a finished result
//  waits in the output register while the next request is accepted.
// ----------------------------------------------------------------------------
module broadcast_drop_oldest_queues
	import bdq_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
	parameter int FRAME_BITS  = FRAME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	bdq_in_if.sink              in_req,
	bdq_out_if.source           out_rsp,
	input  logic                cfg_wr_en,
	input  logic [ACTIVE_W-1:0] cfg_wr_data
);

	localparam int PTR_W     = $clog2(QUEUE_DEPTH);
	localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int Q_W       = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int LIM_W     = $clog2(NUM_QUEUES + 1);
	localparam int MEM_DEPTH = NUM_QUEUES << PTR_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PUSH,
		ST_POP,
		ST_FIN
	} state_t;

	state_t                 state_q;
	logic [ACTIVE_W-1:0]    active_q;
	logic [LIM_W-1:0]       lim_q;
	logic [Q_W-1:0]         cur_q;
	logic [FRAME_BITS-1:0]  frame_q;
	logic                   pop_ok_q;
	logic [STATUS_W-1:0]    status_q;
	logic [FRAME_BITS-1:0]  rd_q;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic [FRAME_W-1:0]     out_frame_q;

	logic [PTR_W-1:0]       rp_q   [NUM_QUEUES];
	logic [PTR_W-1:0]       wp_q   [NUM_QUEUES];
	logic [CNT_W-1:0]       fill_q [NUM_QUEUES];
	logic [FRAME_BITS-1:0]  mem    [MEM_DEPTH];

	logic                   in_fire;
	logic                   out_free;
	logic [LIM_W-1:0]       lim;
	logic [Q_W-1:0]         req_q;
	logic                   pop_ok;
	logic                   mem_we;
	logic [Q_W+PTR_W-1:0]   mem_waddr;
	logic [Q_W+PTR_W-1:0]   mem_raddr;
	logic [PTR_W-1:0]       rp_cur;
	logic [PTR_W-1:0]       wp_cur;
	logic [CNT_W-1:0]       fill_cur;
	logic                   cur_full;
	logic                   push_last;

	// active count saturates at the number of queues
	assign lim = (32'(active_q) > 32'(NUM_QUEUES)) ? LIM_W'(NUM_QUEUES) : LIM_W'(active_q);

	// handshakes
	assign in_req.ready = (state_q == ST_IDLE);
	assign in_fire      = in_req.valid && in_req.ready;
	assign out_free     = !out_valid_q || out_rsp.ready;

	assign out_rsp.valid     = out_valid_q;
	assign out_rsp.status    = out_status_q;
	assign out_rsp.frame_out = out_frame_q;

	// pop check on the incoming request
	assign req_q  = Q_W'(in_req.queue_index);
	assign pop_ok = (32'(in_req.queue_index) < 32'(lim)) && (fill_q[req_q] != '0);

	// per-queue view at the sequencer index
	assign rp_cur    = rp_q[cur_q];
	assign wp_cur    = wp_q[cur_q];
	assign fill_cur  = fill_q[cur_q];
	assign cur_full  = (fill_cur == CNT_W'(QUEUE_DEPTH));
	assign push_last = (32'(cur_q) + 32'd1 == 32'(lim_q));

	assign mem_we    = (state_q == ST_PUSH);
	assign mem_waddr = {cur_q, wp_cur};
	assign mem_raddr = {cur_q, rp_cur};

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_wr_en) begin
			active_q <= cfg_wr_data;
		end
	end

	// frame memory, one write per cycle, read data held from the pop step
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= frame_q;
		end
		if (state_q == ST_POP) begin
			rd_q <= mem[mem_raddr];
		end
	end

	// queue pointers and fill counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rp_q[i]   <= '0;
				wp_q[i]   <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_PUSH: begin
					wp_q[cur_q] <= next_slot(wp_cur);
					if (cur_full) begin
						rp_q[cur_q] <= next_slot(rp_cur);
					end else begin
						fill_q[cur_q] <= fill_cur + 1'b1;
					end
				end
				ST_POP: begin
					rp_q[cur_q]   <= next_slot(rp_cur);
					fill_q[cur_q] <= fill_cur - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			lim_q        <= '0;
			cur_q        <= '0;
			frame_q      <= '0;
			pop_ok_q     <= 1'b0;
			status_q     <= STATUS_OK;
			out_status_q <= STATUS_OK;
			out_frame_q  <= '0;
		end else begin
			if (out_valid_q && out_rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						frame_q <= in_req.frame_in[FRAME_BITS-1:0];
						lim_q   <= lim;
						if (in_req.mode == MODE_PUSH) begin
							cur_q    <= '0;
							pop_ok_q <= 1'b0;
							status_q <= STATUS_OK;
							state_q  <= (lim == '0) ? ST_FIN : ST_PUSH;
						end else begin
							cur_q    <= req_q;
							pop_ok_q <= pop_ok;
							status_q <= pop_ok ? STATUS_OK : STATUS_EMPTY;
							state_q  <= pop_ok ? ST_POP : ST_FIN;
						end
					end
				end
				ST_PUSH: begin
					// one queue written per cycle
					cur_q <= cur_q + 1'b1;
					if (push_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_POP: begin
					// read issued, data lands in rd_q
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_frame_q  <= pop_ok_q ? FRAME_W'(rd_q) : '0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
